[rtl/core/ipv4pe_pkg.sv]
// shared types and constants for the ipv4 pair extract parser
// beat structs for both channels, register layout, frame kinds, ethertypes
// no dependencies
`default_nettype none

package ipv4pe_pkg;

	// field widths
	localparam int BYTE_W        = 8;
	localparam int KIND_W        = 3;
	localparam int ADDR_W        = 32;
	localparam int SLOT_W        = 17;
	localparam int COUNT_W       = 48;
	localparam int POS_W         = 16;
	localparam int TYPE_W        = 16;
	localparam int CFG_RECORDS_W = 18;
	localparam int CFG_WINDOWS_W = 7;

	// configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_RECORDS_PER_WINDOW = 1'b0;
	localparam logic REG_WINDOWS_PER_FILE   = 1'b1;
	localparam logic [CFG_RECORDS_W-1:0] RECORDS_RESET = 18'd131072;
	localparam logic [CFG_WINDOWS_W-1:0] WINDOWS_RESET = 7'd64;

	// frame kinds
	localparam logic [KIND_W-1:0] KIND_IPV4     = 3'd0;
	localparam logic [KIND_W-1:0] KIND_IPV4_TAG = 3'd1;
	localparam logic [KIND_W-1:0] KIND_IPV6     = 3'd2;
	localparam logic [KIND_W-1:0] KIND_SKIPPED  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_DROPPED  = 3'd4;
	localparam logic [KIND_W-1:0] KIND_OTHER    = 3'd5;

	// ethertypes
	localparam logic [TYPE_W-1:0] TYPE_IPV4 = 16'h0800;
	localparam logic [TYPE_W-1:0] TYPE_VLAN = 16'h8100;
	localparam logic [TYPE_W-1:0] TYPE_IPV6 = 16'h86DD;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
	localparam logic [ADDR_W-1:0]  ADDR_ONES = {ADDR_W{1'b1}};

	// counter slots
	localparam int CNT_ALL     = 0;
	localparam int CNT_TAGGED  = 1;
	localparam int CNT_IPV6    = 2;
	localparam int CNT_SKIPPED = 3;
	localparam int NUM_CNT     = 4;

	typedef struct packed {
		logic [BYTE_W-1:0] frame_byte;
		logic              frame_end;
	} in_beat_t;

	typedef struct packed {
		logic [KIND_W-1:0]  frame_kind;
		logic [ADDR_W-1:0]  source_address;
		logic [ADDR_W-1:0]  dest_address;
		logic [SLOT_W-1:0]  record_slot;
		logic               window_full;
		logic               file_full;
		logic [COUNT_W-1:0] packets_seen;
		logic [COUNT_W-1:0] tagged_seen;
		logic [COUNT_W-1:0] ipv6_seen;
		logic [COUNT_W-1:0] skipped_seen;
	} out_beat_t;

	typedef struct packed {
		logic [CFG_RECORDS_W-1:0] records_per_window;
		logic [CFG_WINDOWS_W-1:0] windows_per_file;
	} cfg_t;

endpackage

`default_nettype wire

[rtl/core/ipv4pe_cfg_regs.sv]
// apb-style configuration registers of the ipv4 pair extract parser
// holds records_per_window and windows_per_file, raw as written
// depends on ipv4pe_pkg
`default_nettype none

module ipv4pe_cfg_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [ipv4pe_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [ipv4pe_pkg::PDATA_W-1:0]  pwdata,
	output logic      [ipv4pe_pkg::PDATA_W-1:0]  prdata,
	output logic                                 pready,
	output ipv4pe_pkg::cfg_t                     cfg
);

	logic [ipv4pe_pkg::CFG_RECORDS_W-1:0] records_q;
	logic [ipv4pe_pkg::CFG_WINDOWS_W-1:0] windows_q;
	logic                                 wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	// register write, word index in paddr[2]
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			records_q <= ipv4pe_pkg::RECORDS_RESET;
			windows_q <= ipv4pe_pkg::WINDOWS_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				ipv4pe_pkg::REG_RECORDS_PER_WINDOW: begin
					records_q <= pwdata[ipv4pe_pkg::CFG_RECORDS_W-1:0];
				end
				ipv4pe_pkg::REG_WINDOWS_PER_FILE: begin
					windows_q <= pwdata[ipv4pe_pkg::CFG_WINDOWS_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// read mux
	always_comb begin
		case (paddr[2])
			ipv4pe_pkg::REG_RECORDS_PER_WINDOW: prdata = ipv4pe_pkg::PDATA_W'(records_q);
			ipv4pe_pkg::REG_WINDOWS_PER_FILE:   prdata = ipv4pe_pkg::PDATA_W'(windows_q);
			default:                            prdata = '0;
		endcase
	end

	assign cfg.records_per_window = records_q;
	assign cfg.windows_per_file   = windows_q;

endmodule

`default_nettype wire

[rtl/core/ipv4_pair_extract_parser_core.sv]
// Ethernet frame parser that pulls IPv4 source/destination pairs out of a byte
// stream, following one 802.1Q tag. One byte is taken per clock cycle while
// frame_stall is low, back to back, with no gaps between frames. A byte is
// registered on entry, parsed by a single level of logic against the header
// state and, on the frame's last byte, the result beat is written to the
// output register that drives result_valid. Bytes that do not end a frame
// never wait on the output side; a last byte waits only while an earlier
// result is held by result_stall. Window and file limits are read from the
// config registers and must be changed only while the block is idle; zero
// acts as one and values above the MAX parameters act as those parameters.
// depends on ipv4pe_pkg and ipv4pe_cfg_regs
`default_nettype none

module ipv4_pair_extract_parser_core #(
	parameter int MAX_WINDOW_RECORDS = 131072,
	parameter int MAX_WINDOWS        = 64
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// byte channel
	input  wire logic                            frame_valid,
	output logic                                 frame_stall,
	input  wire ipv4pe_pkg::in_beat_t            frame_data,
	// result channel
	output logic                                 result_valid,
	input  wire logic                            result_stall,
	output ipv4pe_pkg::out_beat_t                result_data,
	// configuration
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [ipv4pe_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [ipv4pe_pkg::PDATA_W-1:0]  pwdata,
	output logic      [ipv4pe_pkg::PDATA_W-1:0]  prdata,
	output logic                                 pready
);

	// record and window counter widths
	localparam int RCNT_W = (MAX_WINDOW_RECORDS > 1) ? $clog2(MAX_WINDOW_RECORDS) : 1;
	localparam int RLIM_W = $clog2(MAX_WINDOW_RECORDS + 1);
	localparam int RW     = ((RLIM_W > ipv4pe_pkg::CFG_RECORDS_W) ?
		RLIM_W : ipv4pe_pkg::CFG_RECORDS_W) + 1;
	localparam int WCNT_W = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
	localparam int WLIM_W = $clog2(MAX_WINDOWS + 1);
	localparam int WW     = ((WLIM_W > ipv4pe_pkg::CFG_WINDOWS_W) ?
		WLIM_W : ipv4pe_pkg::CFG_WINDOWS_W) + 1;
	localparam logic [RW-1:0] RMAX = RW'(MAX_WINDOW_RECORDS);
	localparam logic [WW-1:0] WMAX = WW'(MAX_WINDOWS);

	localparam logic [ipv4pe_pkg::POS_W-1:0] POS_MAX = {ipv4pe_pkg::POS_W{1'b1}};

	ipv4pe_pkg::cfg_t cfg;

	ipv4pe_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// input register and output register
	logic                  valid_s1;
	ipv4pe_pkg::in_beat_t  beat_s1;
	logic                  out_valid_q;
	ipv4pe_pkg::out_beat_t out_beat_q;

	// header state
	logic [ipv4pe_pkg::POS_W-1:0]   pos_q;
	logic [ipv4pe_pkg::TYPE_W-1:0]  outer_q, inner_q;
	logic [3:0]                     ver_q;
	logic [ipv4pe_pkg::ADDR_W-1:0]  src_q, dst_q;
	logic [RCNT_W-1:0]              rec_cnt_q;
	logic [WCNT_W-1:0]              win_cnt_q;
	logic [ipv4pe_pkg::COUNT_W-1:0] cnt_q [ipv4pe_pkg::NUM_CNT];

	logic adv, acc, load_out;

	// handshake: a non-final byte always moves on, a final byte needs the output slot
	assign adv         = valid_s1 && (!beat_s1.frame_end || !out_valid_q || !result_stall);
	assign frame_stall = valid_s1 && !adv;
	assign acc         = frame_valid && !frame_stall;
	assign load_out    = adv && beat_s1.frame_end;

	// byte parse
	logic [ipv4pe_pkg::BYTE_W-1:0]  b;
	logic [ipv4pe_pkg::POS_W-1:0]   base;
	logic [ipv4pe_pkg::TYPE_W-1:0]  outer_nx, inner_nx;
	logic [3:0]                     ver_nx;
	logic [ipv4pe_pkg::ADDR_W-1:0]  src_nx, dst_nx;

	always_comb begin
		b        = beat_s1.frame_byte;
		base     = (outer_q == ipv4pe_pkg::TYPE_VLAN) ? 16'd18 : 16'd14;
		outer_nx = outer_q;
		inner_nx = inner_q;
		ver_nx   = ver_q;
		src_nx   = src_q;
		dst_nx   = dst_q;
		case (pos_q)
			16'd12:  outer_nx = {b, 8'h00};
			16'd13:  outer_nx = outer_q | {8'h00, b};
			16'd16:  inner_nx = {b, 8'h00};
			16'd17:  inner_nx = inner_q | {8'h00, b};
			default: begin
			end
		endcase
		if (pos_q == base)
			ver_nx = b[7:4];
		if (pos_q >= base + 16'd12 && pos_q < base + 16'd16)
			src_nx = {src_q[23:0], b};
		if (pos_q >= base + 16'd16 && pos_q < base + 16'd20)
			dst_nx = {dst_q[23:0], b};
	end

	// frame classification at the last byte
	logic [ipv4pe_pkg::KIND_W-1:0] kind_pre, kind;
	logic                          bump_tag, is_rec;

	always_comb begin
		bump_tag = 1'b0;
		if (pos_q < 16'd13) begin
			kind_pre = ipv4pe_pkg::KIND_SKIPPED;
		end else if (outer_nx == ipv4pe_pkg::TYPE_IPV4) begin
			kind_pre = (pos_q >= 16'd33 && ver_nx == 4'd4) ?
				ipv4pe_pkg::KIND_IPV4 : ipv4pe_pkg::KIND_SKIPPED;
		end else if (outer_nx == ipv4pe_pkg::TYPE_VLAN) begin
			bump_tag = 1'b1;
			kind_pre = (pos_q >= 16'd37 && inner_nx == ipv4pe_pkg::TYPE_IPV4 &&
				ver_nx == 4'd4) ? ipv4pe_pkg::KIND_IPV4_TAG : ipv4pe_pkg::KIND_SKIPPED;
		end else if (outer_nx == ipv4pe_pkg::TYPE_IPV6) begin
			kind_pre = ipv4pe_pkg::KIND_IPV6;
		end else begin
			kind_pre = ipv4pe_pkg::KIND_OTHER;
		end
		is_rec = (kind_pre == ipv4pe_pkg::KIND_IPV4 || kind_pre == ipv4pe_pkg::KIND_IPV4_TAG);
		kind   = kind_pre;
		if (is_rec && (src_nx == ipv4pe_pkg::ADDR_ONES || dst_nx == ipv4pe_pkg::ADDR_ONES)) begin
			kind   = ipv4pe_pkg::KIND_DROPPED;
			is_rec = 1'b0;
		end
	end

	// window and file limits, clamped into range
	logic [RW-1:0]     rcfg, rlim, rplus;
	logic [WW-1:0]     wcfg, wlim, wplus;
	logic              wfull, ffull;
	logic [RCNT_W-1:0] rec_cnt_nx;
	logic [WCNT_W-1:0] win_cnt_nx;

	always_comb begin
		rcfg  = RW'(cfg.records_per_window);
		wcfg  = WW'(cfg.windows_per_file);
		rlim  = (rcfg == '0) ? RW'(1) : ((rcfg > RMAX) ? RMAX : rcfg);
		wlim  = (wcfg == '0) ? WW'(1) : ((wcfg > WMAX) ? WMAX : wcfg);
		rplus = RW'(rec_cnt_q) + RW'(1);
		wplus = WW'(win_cnt_q) + WW'(1);
		wfull = is_rec && (rplus >= rlim);
		ffull = wfull && (wplus >= wlim);
		rec_cnt_nx = rec_cnt_q;
		win_cnt_nx = win_cnt_q;
		if (is_rec)
			rec_cnt_nx = wfull ? '0 : RCNT_W'(rplus);
		if (wfull)
			win_cnt_nx = ffull ? '0 : WCNT_W'(wplus);
	end

	// saturating frame counts
	logic [ipv4pe_pkg::COUNT_W-1:0] cnt_nx [ipv4pe_pkg::NUM_CNT];
	logic [ipv4pe_pkg::NUM_CNT-1:0] bump;

	always_comb begin
		bump[ipv4pe_pkg::CNT_ALL]     = 1'b1;
		bump[ipv4pe_pkg::CNT_TAGGED]  = bump_tag;
		bump[ipv4pe_pkg::CNT_IPV6]    = (kind == ipv4pe_pkg::KIND_IPV6);
		bump[ipv4pe_pkg::CNT_SKIPPED] = (kind == ipv4pe_pkg::KIND_SKIPPED);
		for (int i = 0; i < ipv4pe_pkg::NUM_CNT; i++)
			cnt_nx[i] = (bump[i] && cnt_q[i] != ipv4pe_pkg::COUNT_MAX) ?
				cnt_q[i] + 48'd1 : cnt_q[i];
	end

	// result beat
	ipv4pe_pkg::out_beat_t res_nx;
	logic                  has_addr;

	always_comb begin
		has_addr = is_rec || (kind == ipv4pe_pkg::KIND_DROPPED);
		res_nx.frame_kind     = kind;
		res_nx.source_address = has_addr ? src_nx : '0;
		res_nx.dest_address   = has_addr ? dst_nx : '0;
		res_nx.record_slot    = is_rec ? ipv4pe_pkg::SLOT_W'(rec_cnt_q) : '0;
		res_nx.window_full    = wfull;
		res_nx.file_full      = ffull;
		res_nx.packets_seen   = cnt_nx[ipv4pe_pkg::CNT_ALL];
		res_nx.tagged_seen    = cnt_nx[ipv4pe_pkg::CNT_TAGGED];
		res_nx.ipv6_seen      = cnt_nx[ipv4pe_pkg::CNT_IPV6];
		res_nx.skipped_seen   = cnt_nx[ipv4pe_pkg::CNT_SKIPPED];
	end

	// control and parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			pos_q       <= '0;
			outer_q     <= '0;
			inner_q     <= '0;
			ver_q       <= '0;
			src_q       <= '0;
			dst_q       <= '0;
			rec_cnt_q   <= '0;
			win_cnt_q   <= '0;
			for (int i = 0; i < ipv4pe_pkg::NUM_CNT; i++)
				cnt_q[i] <= '0;
		end else begin
			if (acc)
				valid_s1 <= 1'b1;
			else if (adv)
				valid_s1 <= 1'b0;

			if (load_out)
				out_valid_q <= 1'b1;
			else if (!result_stall)
				out_valid_q <= 1'b0;

			if (adv) begin
				if (beat_s1.frame_end) begin
					pos_q     <= '0;
					outer_q   <= '0;
					inner_q   <= '0;
					ver_q     <= '0;
					src_q     <= '0;
					dst_q     <= '0;
					rec_cnt_q <= rec_cnt_nx;
					win_cnt_q <= win_cnt_nx;
					for (int i = 0; i < ipv4pe_pkg::NUM_CNT; i++)
						cnt_q[i] <= cnt_nx[i];
				end else begin
					pos_q   <= (pos_q == POS_MAX) ? pos_q : pos_q + 16'd1;
					outer_q <= outer_nx;
					inner_q <= inner_nx;
					ver_q   <= ver_nx;
					src_q   <= src_nx;
					dst_q   <= dst_nx;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (acc)
			beat_s1 <= frame_data;
		if (load_out)
			out_beat_q <= res_nx;
	end

	assign result_valid = out_valid_q;
	assign result_data  = out_beat_q;

	// file close only ever comes with a window close
	a_file_needs_window: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (!result_data.file_full || result_data.window_full))
		else $error("file_full without window_full");

	// slot and window flag only on record kinds
	a_slot_only_records: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_data.frame_kind != ipv4pe_pkg::KIND_IPV4 &&
		result_data.frame_kind != ipv4pe_pkg::KIND_IPV4_TAG) |->
		(result_data.record_slot == '0 && !result_data.window_full))
		else $error("record fields set on a non-record result");

	// input side stalls only while the input register is blocked
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		frame_stall |-> (valid_s1 && beat_s1.frame_end && out_valid_q))
		else $error("byte channel stalled without a blocked last byte");

	// a new result counts one more frame than the one before, up to saturation
	a_packets_step: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_stall) ##1 result_valid |->
		(result_data.packets_seen == $past(result_data.packets_seen) + 48'd1 ||
		result_data.packets_seen == ipv4pe_pkg::COUNT_MAX ||
		result_data.packets_seen == $past(result_data.packets_seen, 2) + 48'd1))
		else $error("packets_seen did not step by one");

endmodule

`default_nettype wire

[tb/sv/ipv4_pair_extract_parser_check.sv]
// scoreboard for the ipv4 pair extract parser core: follows the byte, result and
// register ports, predicts every result beat from the accepted bytes and compares it
// depends on ipv4pe_pkg
module ipv4_pair_extract_parser_check
	import ipv4pe_pkg::*;
#(
	parameter int MAX_WINDOW_RECORDS = 131072,
	parameter int MAX_WINDOWS        = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               frame_valid,
	input  logic               frame_stall,
	input  in_beat_t           frame_data,
	input  logic               result_valid,
	input  logic               result_stall,
	input  out_beat_t          result_data,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	input  logic               pready,
	output int unsigned        pending,
	output int unsigned        errors
);
	timeunit 1ns;
	timeprecision 1ps;

	// header layout
	localparam int unsigned TYPE_HI_POS  = 12;
	localparam int unsigned TYPE_LO_POS  = 13;
	localparam int unsigned INNER_HI_POS = 16;
	localparam int unsigned INNER_LO_POS = 17;
	localparam int unsigned ETH_HDR_LEN  = 14;
	localparam int unsigned TAG_HDR_LEN  = 18;
	localparam int unsigned SRC_OFS      = 12;
	localparam int unsigned DST_OFS      = 16;
	localparam int unsigned ADDR_BYTES   = 4;
	localparam int unsigned IPV4_MIN_LEN = 34;
	localparam int unsigned TAG_MIN_LEN  = 38;
	localparam int unsigned POS_LIMIT    = 16'hFFFF;
	localparam logic [3:0]  IP_V4        = 4'd4;

	// register copies
	logic [CFG_RECORDS_W-1:0] cfg_records;
	logic [CFG_WINDOWS_W-1:0] cfg_windows;

	// per-frame header state
	logic [POS_W-1:0]  byte_pos;
	logic [TYPE_W-1:0] outer_type;
	logic [TYPE_W-1:0] inner_type;
	logic [3:0]        ip_version;
	logic [ADDR_W-1:0] src_hold;
	logic [ADDR_W-1:0] dst_hold;

	// record bookkeeping and frame counts
	int unsigned       record_cnt;
	int unsigned       window_cnt;
	logic [COUNT_W-1:0] seen [NUM_CNT];

	out_beat_t frame_results [$];

	function automatic int unsigned clamp_limit(input int unsigned v, input int unsigned ceiling);
		if (v == 0)
			return 1;
		return (v > ceiling) ? ceiling : v;
	endfunction

	task automatic bump(input int which);
		if (seen[which] != COUNT_MAX)
			seen[which]++;
	endtask

	task automatic check_field(input string field, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected %0h got %0h", $time, field, want, got);
		end
	endtask

	// compare one result beat against the oldest prediction
	task automatic compare_result(input out_beat_t got);
		out_beat_t want;

		if (frame_results.size() == 0) begin
			errors++;
			$display("%0t: result beat expected none got %h", $time, got);
		end else begin
			want = frame_results.pop_front();
			check_field("frame_kind", want.frame_kind, got.frame_kind);
			check_field("source_address", want.source_address, got.source_address);
			check_field("dest_address", want.dest_address, got.dest_address);
			check_field("record_slot", want.record_slot, got.record_slot);
			check_field("window_full", want.window_full, got.window_full);
			check_field("file_full", want.file_full, got.file_full);
			check_field("packets_seen", want.packets_seen, got.packets_seen);
			check_field("tagged_seen", want.tagged_seen, got.tagged_seen);
			check_field("ipv6_seen", want.ipv6_seen, got.ipv6_seen);
			check_field("skipped_seen", want.skipped_seen, got.skipped_seen);
		end
	endtask

	// absorb one byte beat; on the last byte of a frame queue the predicted result
	task automatic parse_byte(input in_beat_t beat);
		int unsigned       posn;
		int unsigned       len;
		int unsigned       base;
		int unsigned       rlim;
		int unsigned       wlim;
		logic [BYTE_W-1:0] b;
		out_beat_t         res;

		b = beat.frame_byte;
		posn = byte_pos;
		len = posn + 1;
		base = (outer_type == TYPE_VLAN) ? TAG_HDR_LEN : ETH_HDR_LEN;

		// header field capture
		if (posn == TYPE_HI_POS)
			outer_type = {b, 8'h00};
		else if (posn == TYPE_LO_POS)
			outer_type = outer_type | TYPE_W'(b);
		else if (posn == INNER_HI_POS)
			inner_type = {b, 8'h00};
		else if (posn == INNER_LO_POS)
			inner_type = inner_type | TYPE_W'(b);
		if (posn >= ETH_HDR_LEN && posn == base)
			ip_version = b[7:4];
		if (posn >= ETH_HDR_LEN && posn >= base + SRC_OFS && posn < base + SRC_OFS + ADDR_BYTES)
			src_hold = {src_hold[ADDR_W-BYTE_W-1:0], b};
		if (posn >= ETH_HDR_LEN && posn >= base + DST_OFS && posn < base + DST_OFS + ADDR_BYTES)
			dst_hold = {dst_hold[ADDR_W-BYTE_W-1:0], b};

		if (!beat.frame_end) begin
			if (posn < POS_LIMIT)
				byte_pos = byte_pos + 1'b1;
			return;
		end

		// classify the finished frame
		res = '0;
		bump(CNT_ALL);
		if (len < ETH_HDR_LEN) begin
			res.frame_kind = KIND_SKIPPED;
		end else if (outer_type == TYPE_IPV4) begin
			res.frame_kind = (len >= IPV4_MIN_LEN && ip_version == IP_V4) ? KIND_IPV4 : KIND_SKIPPED;
		end else if (outer_type == TYPE_VLAN) begin
			bump(CNT_TAGGED);
			res.frame_kind = (len >= TAG_MIN_LEN && inner_type == TYPE_IPV4 &&
				ip_version == IP_V4) ? KIND_IPV4_TAG : KIND_SKIPPED;
		end else if (outer_type == TYPE_IPV6) begin
			res.frame_kind = KIND_IPV6;
		end else begin
			res.frame_kind = KIND_OTHER;
		end

		// record slot and window/file closing
		if (res.frame_kind == KIND_SKIPPED) begin
			bump(CNT_SKIPPED);
		end else if (res.frame_kind == KIND_IPV6) begin
			bump(CNT_IPV6);
		end else if (res.frame_kind == KIND_IPV4 || res.frame_kind == KIND_IPV4_TAG) begin
			res.source_address = src_hold;
			res.dest_address = dst_hold;
			if (src_hold == ADDR_ONES || dst_hold == ADDR_ONES) begin
				res.frame_kind = KIND_DROPPED;
			end else begin
				rlim = clamp_limit(cfg_records, MAX_WINDOW_RECORDS);
				wlim = clamp_limit(cfg_windows, MAX_WINDOWS);
				res.record_slot = record_cnt[SLOT_W-1:0];
				if (record_cnt + 1 >= rlim) begin
					record_cnt = 0;
					res.window_full = 1'b1;
					if (window_cnt + 1 >= wlim) begin
						window_cnt = 0;
						res.file_full = 1'b1;
					end else begin
						window_cnt++;
					end
				end else begin
					record_cnt++;
				end
			end
		end

		res.packets_seen = seen[CNT_ALL];
		res.tagged_seen = seen[CNT_TAGGED];
		res.ipv6_seen = seen[CNT_IPV6];
		res.skipped_seen = seen[CNT_SKIPPED];
		frame_results.push_back(res);

		byte_pos = '0;
		outer_type = '0;
		inner_type = '0;
		ip_version = '0;
		src_hold = '0;
		dst_hold = '0;
	endtask

	// result side first, then register writes, then the byte beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_records = RECORDS_RESET;
			cfg_windows = WINDOWS_RESET;
			byte_pos = '0;
			outer_type = '0;
			inner_type = '0;
			ip_version = '0;
			src_hold = '0;
			dst_hold = '0;
			record_cnt = 0;
			window_cnt = 0;
			for (int i = 0; i < NUM_CNT; i++)
				seen[i] = '0;
			frame_results.delete();
			errors = 0;
			pending <= 0;
		end else begin
			if (result_valid && !result_stall)
				compare_result(result_data);
			if (psel && penable && pwrite && pready) begin
				if (paddr[PADDR_W-1:2] == REG_RECORDS_PER_WINDOW)
					cfg_records = pwdata[CFG_RECORDS_W-1:0];
				else if (paddr[PADDR_W-1:2] == REG_WINDOWS_PER_FILE)
					cfg_windows = pwdata[CFG_WINDOWS_W-1:0];
			end
			if (frame_valid && !frame_stall)
				parse_byte(frame_data);
			pending <= frame_results.size();
		end
	end

endmodule

[tb/sv/tb_ipv4_pair_extract_parser_core.sv]
// top of the ipv4 pair extract parser testbench: clock, reset, frame stimulus,
// register writes and the verdict; checking lives in ipv4_pair_extract_parser_check
// depends on ipv4pe_pkg, ipv4_pair_extract_parser_core and the checker
module tb_ipv4_pair_extract_parser_core;
	timeunit 1ns;
	timeprecision 1ps;

	import ipv4pe_pkg::*;

	localparam int MAX_WINDOW_RECORDS = 131072;
	localparam int MAX_WINDOWS        = 64;
	localparam int LATENCY            = 8;

	// frame layout
	localparam int unsigned MAC_BYTES    = 12;
	localparam int unsigned IP_MID_BYTES = 11;
	localparam int unsigned ETH_HDR_LEN  = 14;
	localparam int unsigned IPV4_MIN_LEN = 34;
	localparam int unsigned TAG_MIN_LEN  = 38;
	localparam int unsigned LONG_LEN     = 96;
	localparam logic [3:0]  IP_V4        = 4'd4;

	localparam int unsigned SEG_COUNT  = 6;
	localparam int unsigned SEG_BYTES  = 90;
	localparam int unsigned SEG_FRAMES = 2;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               frame_valid = 1'b0;
	logic               frame_stall;
	in_beat_t           frame_data = '0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	out_beat_t          result_data;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	int unsigned pending;
	int unsigned fail_count;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;

	logic [BYTE_W-1:0] frame_bytes [$];

	ipv4_pair_extract_parser_core #(
		.MAX_WINDOW_RECORDS(MAX_WINDOW_RECORDS),
		.MAX_WINDOWS(MAX_WINDOWS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.frame_valid(frame_valid),
		.frame_stall(frame_stall),
		.frame_data(frame_data),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_data(result_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	ipv4_pair_extract_parser_check #(
		.MAX_WINDOW_RECORDS(MAX_WINDOW_RECORDS),
		.MAX_WINDOWS(MAX_WINDOWS)
	) frame_check (
		.clk(clk),
		.arst_n(arst_n),
		.frame_valid(frame_valid),
		.frame_stall(frame_stall),
		.frame_data(frame_data),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_data(result_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.pready(pready),
		.pending(pending),
		.errors(fail_count)
	);

	// 2 ns clock
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// random backpressure on the result side
	always @(posedge clk)
		result_stall <= ($urandom_range(99) < recv_idle_pct);

	// hard stop for a hung run
	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// one byte beat, with random gaps before it
	task automatic push_byte(input logic [BYTE_W-1:0] b, input logic e);
		while ($urandom_range(99) < send_idle_pct) begin
			frame_valid <= 1'b0;
			@(posedge clk);
		end
		frame_valid <= 1'b1;
		frame_data <= '{frame_byte: b, frame_end: e};
		@(posedge clk);
		while (frame_stall)
			@(posedge clk);
	endtask

	// build a frame with the given header fields, cut or padded to len, and send it
	task automatic send_frame(input logic [TYPE_W-1:0] outer, input logic [TYPE_W-1:0] inner,
			input logic [7:0] ver_ihl, input logic [ADDR_W-1:0] src,
			input logic [ADDR_W-1:0] dst, input int unsigned len);
		frame_bytes.delete();
		for (int i = 0; i < MAC_BYTES; i++)
			frame_bytes.push_back(BYTE_W'($urandom));
		frame_bytes.push_back(outer[15:8]);
		frame_bytes.push_back(outer[7:0]);
		if (outer == TYPE_VLAN) begin
			frame_bytes.push_back(BYTE_W'($urandom));
			frame_bytes.push_back(BYTE_W'($urandom));
			frame_bytes.push_back(inner[15:8]);
			frame_bytes.push_back(inner[7:0]);
		end
		frame_bytes.push_back(ver_ihl);
		for (int i = 0; i < IP_MID_BYTES; i++)
			frame_bytes.push_back(BYTE_W'($urandom));
		for (int i = 3; i >= 0; i--)
			frame_bytes.push_back(src[8*i +: 8]);
		for (int i = 3; i >= 0; i--)
			frame_bytes.push_back(dst[8*i +: 8]);
		while (frame_bytes.size() > len)
			void'(frame_bytes.pop_back());
		while (frame_bytes.size() < len)
			frame_bytes.push_back(BYTE_W'($urandom));
		for (int i = 0; i < len; i++)
			push_byte(frame_bytes[i], i == len - 1);
	endtask

	// one random frame, mostly well-formed address records
	task automatic random_frame(output int unsigned len);
		logic [ADDR_W-1:0] src;
		logic [ADDR_W-1:0] dst;
		logic [7:0]        ver;
		logic [TYPE_W-1:0] outer;
		logic [3:0]        bad_ver;
		int unsigned       pad;
		int unsigned       pick;
		bit                with_tag;

		src = $urandom;
		dst = $urandom;
		if ($urandom_range(15) == 0)
			src = ADDR_ONES;
		else if ($urandom_range(15) == 0)
			dst = ADDR_ONES;
		ver = {IP_V4, 4'($urandom_range(15))};
		pad = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(6);
		with_tag = $urandom_range(1);
		outer = with_tag ? TYPE_VLAN : TYPE_IPV4;
		pick = $urandom_range(99);
		if (pick < 35) begin
			len = IPV4_MIN_LEN + pad;
			send_frame(TYPE_IPV4, TYPE_W'($urandom), ver, src, dst, len);
		end else if (pick < 55) begin
			len = TAG_MIN_LEN + pad;
			send_frame(TYPE_VLAN, TYPE_IPV4, ver, src, dst, len);
		end else if (pick < 63) begin
			len = ETH_HDR_LEN + $urandom_range(50);
			send_frame(TYPE_IPV6, TYPE_W'($urandom), 8'($urandom), src, dst, len);
		end else if (pick < 68) begin
			// tagged frame carrying something other than ipv4
			len = TAG_MIN_LEN + pad;
			send_frame(TYPE_VLAN, $urandom_range(1) ? TYPE_IPV6 : TYPE_W'($urandom),
				ver, src, dst, len);
		end else if (pick < 75) begin
			// ends before the destination address is complete
			len = $urandom_range((with_tag ? TAG_MIN_LEN : IPV4_MIN_LEN) - 1, ETH_HDR_LEN);
			send_frame(outer, TYPE_IPV4, ver, src, dst, len);
		end else if (pick < 80) begin
			bad_ver = 4'($urandom_range(15));
			if (bad_ver == IP_V4)
				bad_ver = bad_ver + 1'b1;
			len = (with_tag ? TAG_MIN_LEN : IPV4_MIN_LEN) + pad;
			send_frame(outer, TYPE_IPV4, {bad_ver, ver[3:0]}, src, dst, len);
		end else if (pick < 88) begin
			len = $urandom_range(ETH_HDR_LEN - 1, 1);
			send_frame(outer, TYPE_IPV4, ver, src, dst, len);
		end else begin
			len = ETH_HDR_LEN + $urandom_range(40);
			send_frame(TYPE_W'($urandom), TYPE_W'($urandom), ver, src, dst, len);
		end
	endtask

	// hold off the sender until every result is back and the pipe is empty
	task automatic drain();
		frame_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [PDATA_W-1:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_limits(input logic [PDATA_W-1:0] records, input logic [PDATA_W-1:0] windows);
		drain();
		write_reg(REG_RECORDS_PER_WINDOW, records);
		write_reg(REG_WINDOWS_PER_FILE, windows);
	endtask

	initial begin
		int unsigned seg_bytes;
		int unsigned seg_frames;
		int unsigned len;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 33;
		recv_idle_pct = 47;
		set_limits(3, 2);

		// directed frames: field extremes, every frame kind, short and long frames
		send_frame(TYPE_IPV4, 16'h0000, 8'h45, 32'h0000_0000, 32'h0000_0000, IPV4_MIN_LEN);
		send_frame(TYPE_IPV4, 16'h0000, 8'h4F, 32'hFFFF_FFFE, 32'h0000_0001, IPV4_MIN_LEN + 6);
		send_frame(TYPE_VLAN, TYPE_IPV4, 8'h40, 32'h8000_0000, 32'h7FFF_FFFF, TAG_MIN_LEN);
		send_frame(TYPE_IPV4, 16'h0000, 8'h45, ADDR_ONES, 32'h0A00_0001, 40);
		send_frame(TYPE_VLAN, TYPE_IPV4, 8'h45, 32'hC0A8_0001, ADDR_ONES, 42);
		send_frame(TYPE_IPV6, 16'h0000, 8'h60, 32'h2001_0DB8, 32'h0000_0001, 54);
		send_frame(TYPE_VLAN, TYPE_IPV6, 8'h60, 32'h1234_5678, 32'h9ABC_DEF0, 58);
		send_frame(TYPE_IPV4, 16'h0000, 8'h65, 32'h0102_0304, 32'h0506_0708, 40);
		send_frame(TYPE_VLAN, TYPE_IPV4, 8'h35, 32'h0102_0304, 32'h0506_0708, 44);
		send_frame(TYPE_IPV4, 16'h0000, 8'h45, 32'h0A0B_0C0D, 32'h0E0F_1011, IPV4_MIN_LEN - 1);
		send_frame(TYPE_VLAN, TYPE_IPV4, 8'h45, 32'h0A0B_0C0D, 32'h0E0F_1011, TAG_MIN_LEN - 1);
		send_frame(TYPE_VLAN, TYPE_IPV4, 8'h45, 32'h0, 32'h0, ETH_HDR_LEN);
		send_frame(TYPE_IPV4, 16'h0000, 8'h45, 32'h0, 32'h0, ETH_HDR_LEN - 1);
		send_frame(TYPE_IPV4, 16'h0000, 8'h45, 32'h0, 32'h0, 1);
		send_frame(16'h1234, 16'h0000, 8'h45, 32'h0, 32'h0, 60);
		send_frame(16'h0000, 16'h0000, 8'h45, 32'h0, 32'h0, ETH_HDR_LEN);
		send_frame(16'hFFFF, 16'hFFFF, 8'hFF, ADDR_ONES, ADDR_ONES, 20);
		send_frame(TYPE_IPV4, 16'h0000, 8'h45, 32'hAC10_0001, 32'hAC10_0002, 40);
		send_frame(TYPE_VLAN, TYPE_IPV4, 8'h45, 32'h5555_AAAA, 32'hAAAA_5555, 39);
		send_frame(TYPE_VLAN, TYPE_IPV4, 8'h45, 32'hDEAD_BEEF, 32'hFEED_F00D, LONG_LEN);
		send_frame(TYPE_IPV4, 16'h0000, 8'h45, 32'h0000_00FF, 32'hFF00_0000, IPV4_MIN_LEN);
		send_frame(TYPE_IPV4, 16'h0000, 8'h45, 32'h00FF_0000, 32'h0000_FF00, IPV4_MIN_LEN);

		// random segments, each under its own limits
		for (int seg = 0; seg < SEG_COUNT; seg++) begin
			if (seg == 2) begin
				send_idle_pct = 47;
				recv_idle_pct = 33;
			end else if (seg == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			case (seg)
				0: set_limits(0, 0);
				1: set_limits(262143, 127);
				2: set_limits(1, 64);
				3: set_limits(2, 1);
				4: set_limits(131072, 64);
				default: set_limits(7, 3);
			endcase
			seg_bytes = 0;
			seg_frames = 0;
			while (seg_bytes < SEG_BYTES || seg_frames < SEG_FRAMES) begin
				random_frame(len);
				seg_bytes += len;
				seg_frames++;
			end
		end

		drain();
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
